// ===== sv/ansi_text_console_engine_assert.svh =====
// ----------------------------------------------------------------------------
// ansi_text_console_engine_assert.svh
// assertion macros shared by the console engine checkers
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define ANSI_TEXT_CONSOLE_ENGINE_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define ATCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atce assertion failed");

// next-cycle implication, quiet while reset is asserted
`define ATCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atce assertion failed");

`endif

// ===== sv/atce_pkg.sv =====
// ----------------------------------------------------------------------------
// atce_pkg
// shared constants, codes and types of the text console engine
// ----------------------------------------------------------------------------
package atce_pkg;

    localparam int COLUMNS         = 80;
    localparam int ROWS            = 25;
    localparam int TAB_WIDTH       = 8;
    localparam int MAX_PARAM_BYTES = 4;
    localparam int VALUE_MAX       = 9999;
    localparam int FIFO_DEPTH      = 4;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int WORD_W = 16;
    localparam int VAL_W  = 14;
    localparam int SUM_W  = VAL_W + 1;
    localparam int MUL_W  = VAL_W + 4;
    localparam int PB_W   = $clog2(MAX_PARAM_BYTES + 1);

    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CSI   = 8'h5B;
    localparam logic [7:0] CH_RIS   = 8'h63;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CUU   = 8'h41;
    localparam logic [7:0] CH_CUD   = 8'h42;
    localparam logic [7:0] CH_CUF   = 8'h43;
    localparam logic [7:0] CH_CUB   = 8'h44;
    localparam logic [7:0] CH_CUP   = 8'h48;
    localparam logic [7:0] CH_SCP   = 8'h73;
    localparam logic [7:0] CH_RCP   = 8'h75;

    localparam int FL_BAD0 = 0;
    localparam int FL_BAD1 = 1;
    localparam int FL_ANY1 = 2;
    localparam int FL_ANY2 = 3;

    typedef enum logic [1:0] {
        ACT_CURSOR = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SCROLL = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_BAD    = 2'd3
    } t_mode;

    typedef struct packed {
        t_action            action;
        logic [IDX_W-1:0]   cell_index;
        logic [WORD_W-1:0]  cell_word;
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== sv/atce_byte_if.sv =====
// ----------------------------------------------------------------------------
// atce_byte_if
// input byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface atce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

// ===== sv/atce_result_if.sv =====
// ----------------------------------------------------------------------------
// atce_result_if
// result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface atce_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [atce_pkg::IDX_W-1:0]   cell_index;
    logic [atce_pkg::WORD_W-1:0]  cell_word;
    logic [atce_pkg::COL_W-1:0]   cursor_col;
    logic [atce_pkg::ROW_W-1:0]   cursor_row;
    logic                         last;

    modport source (output valid, output action, output cell_index, output cell_word,
                    output cursor_col, output cursor_row, output last, input ready);
    modport sink (input valid, input action, input cell_index, input cell_word,
                  input cursor_col, input cursor_row, input last, output ready);
endinterface

// ===== sv/atce_core.sv =====
// ----------------------------------------------------------------------------
// atce_core
// escape parser and cursor state; turns one byte into up to two results
// ----------------------------------------------------------------------------
module atce_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_char,
    input  logic [7:0]           i_attr,
    output atce_pkg::t_push      o_push
);

    atce_pkg::t_mode r_mode, n_mode;

    logic [atce_pkg::COL_W-1:0] r_col, n_col, r_saved_col, n_saved_col;
    logic [atce_pkg::ROW_W-1:0] r_row, n_row, r_saved_row, n_saved_row;
    logic [atce_pkg::PB_W-1:0]  r_pb, n_pb;
    logic [1:0]                 r_argc, n_argc;
    logic [atce_pkg::VAL_W-1:0] r_first, n_first, r_second, n_second;
    logic [3:0]                 r_flags, n_flags;

    logic is_letter, is_digit, is_semi, none;
    logic [atce_pkg::WORD_W-1:0] blank;

    // plain byte path
    logic [7:0]                  pc;
    logic [5:0]                  pr;
    logic [atce_pkg::COL_W-1:0]  p_col;
    logic [atce_pkg::ROW_W-1:0]  p_row;
    logic                        p_wrote, p_scroll, p_silent;
    logic [atce_pkg::IDX_W-1:0]  p_idx;
    logic [atce_pkg::WORD_W-1:0] p_word;

    // final letter path
    logic                        s_move, s_save;
    logic [atce_pkg::COL_W-1:0]  s_col;
    logic [atce_pkg::ROW_W-1:0]  s_row;
    logic [atce_pkg::VAL_W-1:0]  x, y, cnt;
    logic [atce_pkg::SUM_W-1:0]  sum;

    // parameter byte path
    logic [1:0]                  t_argc;
    logic [atce_pkg::VAL_W-1:0]  t_first, t_second;
    logic [3:0]                  t_flags;
    logic [atce_pkg::MUL_W-1:0]  acc_first, acc_second;

    assign is_letter = (i_char inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign is_digit  = (i_char inside {[atce_pkg::CH_ZERO:atce_pkg::CH_NINE]});
    assign is_semi   = (i_char == atce_pkg::CH_SEMI);
    assign none      = (r_pb == '0);
    assign blank     = {i_attr, atce_pkg::CH_SPACE};

    always_comb begin
        pc       = {1'b0, r_col};
        pr       = {1'b0, r_row};
        p_wrote  = 1'b0;
        p_scroll = 1'b0;
        p_silent = 1'b0;
        p_idx    = '0;
        p_word   = '0;
        if (i_char == atce_pkg::CH_TAB) begin
            pc = 8'(((32'(r_col) / atce_pkg::TAB_WIDTH) + 1) * atce_pkg::TAB_WIDTH);
        end else if (i_char == atce_pkg::CH_NL) begin
            pc = '0;
            pr = pr + 6'd1;
        end else if (i_char == atce_pkg::CH_BS) begin
            if (r_col == '0) begin
                p_silent = 1'b1;
            end else begin
                pc      = pc - 8'd1;
                p_idx   = atce_pkg::IDX_W'(32'(r_row) * atce_pkg::COLUMNS + 32'(r_col) - 1);
                p_word  = blank;
                p_wrote = 1'b1;
            end
        end else if (i_char >= atce_pkg::CH_SPACE) begin
            p_idx   = atce_pkg::IDX_W'(32'(r_row) * atce_pkg::COLUMNS + 32'(r_col));
            p_word  = {i_attr, i_char};
            p_wrote = 1'b1;
            pc      = pc + 8'd1;
        end
        if (pc >= 8'(atce_pkg::COLUMNS)) begin
            pc = '0;
            pr = pr + 6'd1;
        end
        if (pr >= 6'(atce_pkg::ROWS)) begin
            pr       = 6'(atce_pkg::ROWS - 1);
            p_scroll = 1'b1;
        end
        p_col = pc[atce_pkg::COL_W-1:0];
        p_row = pr[atce_pkg::ROW_W-1:0];
    end

    always_comb begin
        s_move = 1'b0;
        s_save = 1'b0;
        s_col  = r_col;
        s_row  = r_row;
        x      = '0;
        y      = '0;
        cnt    = none ? atce_pkg::VAL_W'(1) : r_first;
        sum    = '0;
        case (i_char)
            atce_pkg::CH_CUP: begin
                s_move = 1'b1;
                if (!none) begin
                    if (r_flags[atce_pkg::FL_BAD0]) begin
                        s_move = 1'b0;
                    end else begin
                        x = r_first;
                        if (r_argc != 2'd0 && r_flags[atce_pkg::FL_ANY1]) begin
                            if (r_flags[atce_pkg::FL_BAD1] || r_flags[atce_pkg::FL_ANY2]) begin
                                s_move = 1'b0;
                            end else begin
                                y = r_second;
                            end
                        end
                    end
                end
                if (s_move) begin
                    if (x < atce_pkg::VAL_W'(atce_pkg::COLUMNS)) begin
                        s_col = x[atce_pkg::COL_W-1:0];
                    end
                    if (y < atce_pkg::VAL_W'(atce_pkg::ROWS)) begin
                        s_row = y[atce_pkg::ROW_W-1:0];
                    end
                end
            end
            atce_pkg::CH_CUU, atce_pkg::CH_CUD, atce_pkg::CH_CUF, atce_pkg::CH_CUB: begin
                s_move = none || !(r_flags[atce_pkg::FL_BAD0] || r_flags[atce_pkg::FL_ANY1]);
                if (s_move) begin
                    if (i_char == atce_pkg::CH_CUU) begin
                        s_row = (cnt > atce_pkg::VAL_W'(r_row)) ? '0 :
                                atce_pkg::ROW_W'(atce_pkg::VAL_W'(r_row) - cnt);
                    end else if (i_char == atce_pkg::CH_CUD) begin
                        sum   = atce_pkg::SUM_W'(r_row) + atce_pkg::SUM_W'(cnt);
                        s_row = (sum > atce_pkg::SUM_W'(atce_pkg::ROWS - 1)) ?
                                atce_pkg::ROW_W'(atce_pkg::ROWS - 1) : atce_pkg::ROW_W'(sum);
                    end else if (i_char == atce_pkg::CH_CUF) begin
                        sum   = atce_pkg::SUM_W'(r_col) + atce_pkg::SUM_W'(cnt);
                        s_col = (sum > atce_pkg::SUM_W'(atce_pkg::COLUMNS - 1)) ?
                                atce_pkg::COL_W'(atce_pkg::COLUMNS - 1) : atce_pkg::COL_W'(sum);
                    end else begin
                        s_col = (cnt > atce_pkg::VAL_W'(r_col)) ? '0 :
                                atce_pkg::COL_W'(atce_pkg::VAL_W'(r_col) - cnt);
                    end
                end
            end
            atce_pkg::CH_SCP: begin
                s_save = none;
            end
            atce_pkg::CH_RCP: begin
                if (none) begin
                    s_move = 1'b1;
                    s_col  = r_saved_col;
                    s_row  = r_saved_row;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        t_argc     = r_argc;
        t_first    = r_first;
        t_second   = r_second;
        t_flags    = r_flags;
        acc_first  = atce_pkg::MUL_W'(32'(r_first) * 10 + 32'(i_char[3:0]));
        acc_second = atce_pkg::MUL_W'(32'(r_second) * 10 + 32'(i_char[3:0]));
        if (r_argc >= 2'd2) begin
            t_flags[atce_pkg::FL_ANY2] = 1'b1;
            if (is_semi && r_argc < 2'd3) begin
                t_argc = r_argc + 2'd1;
            end
        end else if (r_argc == 2'd0) begin
            if (is_semi) begin
                if (none) begin
                    t_flags[atce_pkg::FL_BAD0] = 1'b1;
                end
                t_argc = 2'd1;
            end else if (is_digit) begin
                t_first = (acc_first > atce_pkg::MUL_W'(atce_pkg::VALUE_MAX)) ?
                          atce_pkg::VAL_W'(atce_pkg::VALUE_MAX) : atce_pkg::VAL_W'(acc_first);
            end else begin
                t_flags[atce_pkg::FL_BAD0] = 1'b1;
            end
        end else begin
            if (is_semi) begin
                if (!r_flags[atce_pkg::FL_ANY1]) begin
                    t_flags[atce_pkg::FL_BAD1] = 1'b1;
                end
                t_argc = 2'd2;
            end else if (is_digit) begin
                t_second = (acc_second > atce_pkg::MUL_W'(atce_pkg::VALUE_MAX)) ?
                           atce_pkg::VAL_W'(atce_pkg::VALUE_MAX) : atce_pkg::VAL_W'(acc_second);
            end else begin
                t_flags[atce_pkg::FL_BAD1] = 1'b1;
            end
            t_flags[atce_pkg::FL_ANY1] = 1'b1;
        end
    end

    // parser next state
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            atce_pkg::MODE_NORMAL: begin
                if (i_char == atce_pkg::CH_ESC) begin
                    n_mode = atce_pkg::MODE_ESC;
                end
            end
            atce_pkg::MODE_ESC: begin
                n_mode = (i_char == atce_pkg::CH_CSI) ? atce_pkg::MODE_CSI :
                                                         atce_pkg::MODE_NORMAL;
            end
            atce_pkg::MODE_CSI: begin
                if (is_letter) begin
                    n_mode = atce_pkg::MODE_NORMAL;
                end else if (32'(r_pb) >= atce_pkg::MAX_PARAM_BYTES) begin
                    n_mode = atce_pkg::MODE_BAD;
                end
            end
            atce_pkg::MODE_BAD: begin
                if (is_letter) begin
                    n_mode = atce_pkg::MODE_NORMAL;
                end
            end
            default: begin
                n_mode = atce_pkg::MODE_NORMAL;
            end
        endcase
    end

    // cursor, parameters and results
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_saved_col = r_saved_col;
        n_saved_row = r_saved_row;
        n_pb        = r_pb;
        n_argc      = r_argc;
        n_first     = r_first;
        n_second    = r_second;
        n_flags     = r_flags;
        o_push      = '0;
        case (r_mode)
            atce_pkg::MODE_NORMAL, atce_pkg::MODE_ESC: begin
                if (r_mode == atce_pkg::MODE_NORMAL && i_char == atce_pkg::CH_ESC) begin
                    o_push.count = 2'd0;
                end else if (r_mode == atce_pkg::MODE_ESC && i_char == atce_pkg::CH_CSI) begin
                    n_pb     = '0;
                    n_argc   = '0;
                    n_first  = '0;
                    n_second = '0;
                    n_flags  = '0;
                end else if (r_mode == atce_pkg::MODE_ESC && i_char == atce_pkg::CH_RIS) begin
                    n_col                  = '0;
                    n_row                  = '0;
                    o_push.count           = 2'd1;
                    o_push.first.action    = atce_pkg::ACT_CLEAR;
                    o_push.first.cell_word = blank;
                end else if (!p_silent) begin
                    n_col = p_col;
                    n_row = p_row;
                    if (p_wrote) begin
                        o_push.first.action     = atce_pkg::ACT_WRITE;
                        o_push.first.cell_index = p_idx;
                        o_push.first.cell_word  = p_word;
                        o_push.second.action    = atce_pkg::ACT_SCROLL;
                        o_push.second.cell_word = blank;
                        o_push.count            = p_scroll ? 2'd2 : 2'd1;
                    end else if (p_scroll) begin
                        o_push.first.action    = atce_pkg::ACT_SCROLL;
                        o_push.first.cell_word = blank;
                        o_push.count           = 2'd1;
                    end else begin
                        o_push.first.action = atce_pkg::ACT_CURSOR;
                        o_push.count        = 2'd1;
                    end
                end
            end
            atce_pkg::MODE_CSI: begin
                if (is_letter) begin
                    n_col = s_col;
                    n_row = s_row;
                    if (s_save) begin
                        n_saved_col = r_col;
                        n_saved_row = r_row;
                    end
                    if (s_move) begin
                        o_push.first.action = atce_pkg::ACT_CURSOR;
                        o_push.count        = 2'd1;
                    end
                end else if (32'(r_pb) < atce_pkg::MAX_PARAM_BYTES) begin
                    n_argc   = t_argc;
                    n_first  = t_first;
                    n_second = t_second;
                    n_flags  = t_flags;
                    n_pb     = r_pb + atce_pkg::PB_W'(1);
                end
            end
            default: begin
            end
        endcase
        o_push.first.cursor_col  = n_col;
        o_push.first.cursor_row  = n_row;
        o_push.first.last        = (o_push.count == 2'd1);
        o_push.second.cursor_col = n_col;
        o_push.second.cursor_row = n_row;
        o_push.second.last       = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= atce_pkg::MODE_NORMAL;
            r_col       <= '0;
            r_row       <= '0;
            r_saved_col <= '0;
            r_saved_row <= '0;
            r_pb        <= '0;
            r_argc      <= '0;
            r_first     <= '0;
            r_second    <= '0;
            r_flags     <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_col       <= n_col;
            r_row       <= n_row;
            r_saved_col <= n_saved_col;
            r_saved_row <= n_saved_row;
            r_pb        <= n_pb;
            r_argc      <= n_argc;
            r_first     <= n_first;
            r_second    <= n_second;
            r_flags     <= n_flags;
        end
    end

endmodule

// ===== sv/atce_result_fifo.sv =====
// ----------------------------------------------------------------------------
// atce_result_fifo
// result register queue; takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
module atce_result_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  atce_pkg::t_push         i_push,
    output logic                    o_room,
    atce_result_if.source           o_result
);

    localparam int PTR_W = $clog2(atce_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(atce_pkg::FIFO_DEPTH + 1);

    atce_pkg::t_result r_mem [atce_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;
    atce_pkg::t_result head;

    assign pop    = o_result.valid && o_result.ready;
    assign o_room = (32'(r_count) <= atce_pkg::FIFO_DEPTH - 2);
    assign head   = r_mem[r_rd];

    assign o_result.valid      = (r_count != '0);
    assign o_result.action     = head.action;
    assign o_result.cell_index = head.cell_index;
    assign o_result.cell_word  = head.cell_word;
    assign o_result.cursor_col = head.cursor_col;
    assign o_result.cursor_row = head.cursor_row;
    assign o_result.last       = head.last;

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.count);
        n_rd    = pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[PTR_W'(r_wr + PTR_W'(1))] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/ansi_text_console_engine.sv =====
// ----------------------------------------------------------------------------
// ansi_text_console_engine
// byte stream to text screen cell writes, scrolls, clears and cursor moves
// ----------------------------------------------------------------------------
// i_byte carries one stream byte per transaction; o_result carries screen
// actions with the cursor position after the byte. A byte gives zero, one
// or two results; last marks the final one of a byte.
// i_cfg_we / i_cfg_data load the attribute byte (reset value 0x07); write it
// only while no byte is in flight.
// A byte is registered at acceptance, decoded once the result queue has
// room, and its results land in a four-entry result queue. Bytes are taken
// every cycle while the queue has two free entries. The queue hands out one
// result a cycle while the receiver is ready, so single-result bytes
// sustain one byte per cycle, while write-plus-scroll bytes put in two
// results for each one that leaves and fill the queue until intake stalls.
// When the receiver stalls, the queue fills and i_byte.ready drops; nothing
// is lost. Reset empties the queue, homes and clears the saved cursor and
// returns the parser to plain text.
// ----------------------------------------------------------------------------
module ansi_text_console_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    atce_byte_if.sink     i_byte,
    atce_result_if.source o_result
);

    logic            r_in_valid, n_in_valid;
    logic [7:0]      r_in_byte;
    logic [7:0]      r_attr;
    logic            room, fire, take;
    atce_pkg::t_push push;

    assign fire         = r_in_valid && room;
    assign i_byte.ready = !r_in_valid || fire;
    assign take         = i_byte.valid && i_byte.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (take) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_attr     <= atce_pkg::ATTR_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    atce_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_byte),
        .i_attr  (r_attr),
        .o_push  (push)
    );

    atce_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire ? push : '0),
        .o_room   (room),
        .o_result (o_result)
    );

endmodule

// ===== sv/atce_checker.sv =====
// ----------------------------------------------------------------------------
// atce_checker
// port-level checks of the console engine, bound to the top level
// ----------------------------------------------------------------------------
`include "ansi_text_console_engine_assert.svh"

module atce_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [1:0]                   i_action,
    input logic [atce_pkg::IDX_W-1:0]   i_cell_index,
    input logic [atce_pkg::WORD_W-1:0]  i_cell_word,
    input logic [atce_pkg::COL_W-1:0]   i_cursor_col,
    input logic [atce_pkg::ROW_W-1:0]   i_cursor_row,
    input logic                         i_last
);

    `ATCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_action) && $stable(i_cell_index) && $stable(i_cell_word) && $stable(i_last))
    `ATCE_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, i_out_valid, i_cursor_col < atce_pkg::COL_W'(atce_pkg::COLUMNS) && i_cursor_row < atce_pkg::ROW_W'(atce_pkg::ROWS))
    `ATCE_ASSERT_NOW(a_cursor_only, i_clk, i_rst_n, i_out_valid && i_action == atce_pkg::ACT_CURSOR, i_cell_index == '0 && i_cell_word == '0 && i_last)
    `ATCE_ASSERT_NOW(a_fill_blank, i_clk, i_rst_n, i_out_valid && (i_action == atce_pkg::ACT_SCROLL || i_action == atce_pkg::ACT_CLEAR), i_last && i_cell_index == '0 && i_cell_word[7:0] == atce_pkg::CH_SPACE)

endmodule

bind ansi_text_console_engine atce_checker u_atce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_action     (o_result.action),
    .i_cell_index (o_result.cell_index),
    .i_cell_word  (o_result.cell_word),
    .i_cursor_col (o_result.cursor_col),
    .i_cursor_row (o_result.cursor_row),
    .i_last       (o_result.last)
);
